[sv/click_gesture_classifier_defines.svh]
// ----------------------------------------------------------------------------
// Click gesture classifier assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef CLICK_GESTURE_CLASSIFIER_DEFINES_SVH
`define CLICK_GESTURE_CLASSIFIER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CGC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CGC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/cgc_pkg.sv]
// ----------------------------------------------------------------------------
// cgc_pkg
// Mode codes, register indexes and defaults for the click gesture classifier.
// ----------------------------------------------------------------------------
package cgc_pkg;

    localparam int TIME_WIDTH_DEF = 32;
    localparam int NOW_W          = 32;
    localparam int LIMIT_W        = 16;
    localparam int MODE_W         = 3;
    localparam int CFG_INDEX_W    = 2;
    localparam int CFG_DATA_W     = 16;
    localparam int S_DATA_W       = 40;
    localparam int M_DATA_W       = 8;

    localparam logic [MODE_W-1:0] MODE_IDLE        = 3'd0;
    localparam logic [MODE_W-1:0] MODE_WAIT        = 3'd1;
    localparam logic [MODE_W-1:0] MODE_LONG        = 3'd2;
    localparam logic [MODE_W-1:0] MODE_WAIT_DOUBLE = 3'd3;
    localparam logic [MODE_W-1:0] MODE_SINGLE      = 3'd4;
    localparam logic [MODE_W-1:0] MODE_DOUBLE      = 3'd5;

    localparam logic [CFG_INDEX_W-1:0] REG_DOUBLE_LIMIT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_LONG_LIMIT   = 2'd1;

    localparam logic [LIMIT_W-1:0] DOUBLE_LIMIT_RST = 16'd300;
    localparam logic [LIMIT_W-1:0] LONG_LIMIT_RST   = 16'd700;

endpackage

[sv/cgc_step.sv]
// ----------------------------------------------------------------------------
// cgc_step
// Next-mode and press-start logic for one poll of the click classifier.
// ----------------------------------------------------------------------------
module cgc_step #(
    parameter int TIME_WIDTH = cgc_pkg::TIME_WIDTH_DEF
) (
    input  logic [cgc_pkg::MODE_W-1:0]  mode,
    input  logic [TIME_WIDTH-1:0]       press_start,
    input  logic [TIME_WIDTH-1:0]       now,
    input  logic                        pressed,
    input  logic                        released,
    input  logic [cgc_pkg::LIMIT_W-1:0] double_limit,
    input  logic [cgc_pkg::LIMIT_W-1:0] long_limit,
    output logic [cgc_pkg::MODE_W-1:0]  mode_next,
    output logic [TIME_WIDTH-1:0]       press_start_next
);

    localparam int CMP_W = (TIME_WIDTH > cgc_pkg::LIMIT_W) ? TIME_WIDTH : cgc_pkg::LIMIT_W;

    logic [TIME_WIDTH-1:0] elapsed;
    logic [CMP_W-1:0]      elapsed_ext;
    logic [CMP_W-1:0]      double_ext;
    logic [CMP_W-1:0]      long_ext;
    logic                  over_double;
    logic                  over_long;

    // Wrapping difference, then widen both sides to a common width
    assign elapsed     = now - press_start;
    assign elapsed_ext = CMP_W'(elapsed);
    assign double_ext  = CMP_W'(double_limit);
    assign long_ext    = CMP_W'(long_limit);
    assign over_double = elapsed_ext > double_ext;
    assign over_long   = elapsed_ext > long_ext;

    always_comb
    begin
        mode_next        = mode;
        press_start_next = press_start;
        case (mode)
            cgc_pkg::MODE_IDLE:
            begin
                if (pressed)
                begin
                    press_start_next = now;
                    mode_next        = cgc_pkg::MODE_WAIT;
                end
            end
            cgc_pkg::MODE_WAIT:
            begin
                // timeout outranks the release
                if (over_long)
                    mode_next = cgc_pkg::MODE_LONG;
                else if (released)
                    mode_next = cgc_pkg::MODE_WAIT_DOUBLE;
            end
            cgc_pkg::MODE_LONG:
            begin
                if (released)
                    mode_next = cgc_pkg::MODE_IDLE;
            end
            cgc_pkg::MODE_WAIT_DOUBLE:
            begin
                if (over_double)
                    mode_next = cgc_pkg::MODE_SINGLE;
                else if (pressed)
                    mode_next = cgc_pkg::MODE_DOUBLE;
            end
            cgc_pkg::MODE_SINGLE,
            cgc_pkg::MODE_DOUBLE:
            begin
                mode_next = cgc_pkg::MODE_IDLE;
            end
            default:
            begin
                mode_next = mode;
            end
        endcase
    end

endmodule

[sv/click_gesture_classifier.sv]
// ----------------------------------------------------------------------------
// click_gesture_classifier
// Sorts polled button events into single click, double click and long press.
// ----------------------------------------------------------------------------
// Each poll transfer carries the current time and the press and release flags;
// it is turned into one result transfer holding the updated mode (0 idle,
// 1 wait, 2 long, 3 wait double, 4 single, 5 double). The mode update is a
// single subtract and two compares feeding the mode and press-start
// registers, which also serve as the result register, so a poll is taken
// every cycle while the result side keeps up (s_tready is high when no
// result is held or the held one is being taken). Elapsed time wraps
// modulo 2^TIME_WIDTH and is compared strictly with the limits; only the low
// TIME_WIDTH bits of now_time are used. Limits are written on the cfg port,
// index 0 double-click limit, index 1 long-press limit; other indexes are
// ignored.
// ----------------------------------------------------------------------------
module click_gesture_classifier #(
    parameter int TIME_WIDTH = cgc_pkg::TIME_WIDTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [31:0] now_time, [32] press_seen, [33] release_seen, [39:34] zero
    input  logic [cgc_pkg::S_DATA_W-1:0]    s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [2:0] click_mode, [7:3] zero
    output logic [cgc_pkg::M_DATA_W-1:0]    m_tdata,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [cgc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [cgc_pkg::CFG_DATA_W-1:0]  cfg_data
);

    `include "click_gesture_classifier_defines.svh"

    logic [cgc_pkg::MODE_W-1:0]  mode_reg;
    logic [cgc_pkg::MODE_W-1:0]  mode_next;
    logic [TIME_WIDTH-1:0]       press_start_reg;
    logic [TIME_WIDTH-1:0]       press_start_next;
    logic                        m_tvalid_reg;
    logic [cgc_pkg::LIMIT_W-1:0] double_limit_reg;
    logic [cgc_pkg::LIMIT_W-1:0] long_limit_reg;
    logic [2*cgc_pkg::NOW_W-1:0] now_wide;
    logic [TIME_WIDTH-1:0]       now;
    logic                        s_accept;

    assign s_tready  = !m_tvalid_reg || m_tready;
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = cgc_pkg::M_DATA_W'(mode_reg);

    // zero-extend before the cut so widths above 32 read zeros on top
    assign now_wide = {{cgc_pkg::NOW_W{1'b0}}, s_tdata[cgc_pkg::NOW_W-1:0]};
    assign now      = now_wide[TIME_WIDTH-1:0];

    cgc_step #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_step (
        .mode             (mode_reg),
        .press_start      (press_start_reg),
        .now              (now),
        .pressed          (s_tdata[cgc_pkg::NOW_W]),
        .released         (s_tdata[cgc_pkg::NOW_W+1]),
        .double_limit     (double_limit_reg),
        .long_limit       (long_limit_reg),
        .mode_next        (mode_next),
        .press_start_next (press_start_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= cgc_pkg::MODE_IDLE;
            press_start_reg <= '0;
            m_tvalid_reg    <= 1'b0;
        end
        else
        begin
            if (s_accept)
            begin
                mode_reg        <= mode_next;
                press_start_reg <= press_start_next;
                m_tvalid_reg    <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            double_limit_reg <= cgc_pkg::DOUBLE_LIMIT_RST;
            long_limit_reg   <= cgc_pkg::LONG_LIMIT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                cgc_pkg::REG_DOUBLE_LIMIT: double_limit_reg <= cfg_data;
                cgc_pkg::REG_LONG_LIMIT:   long_limit_reg   <= cfg_data;
                default:                   ;
            endcase
        end
    end

    `CGC_ASSERT_NEXT(a_click_returns_idle,
        s_accept && (mode_reg == cgc_pkg::MODE_SINGLE || mode_reg == cgc_pkg::MODE_DOUBLE),
        mode_reg == cgc_pkg::MODE_IDLE,
        "single or double click did not return to idle")
    `CGC_ASSERT_NEXT(a_poll_gives_result, s_accept, m_tvalid,
        "accepted poll produced no result")
    `CGC_ASSERT_NEXT(a_press_start_held,
        !(s_accept && mode_reg == cgc_pkg::MODE_IDLE),
        $stable(press_start_reg),
        "press start changed outside an idle poll")
    `CGC_ASSERT_SAME(a_stall_blocks_input, m_tvalid && !m_tready, !s_tready,
        "poll taken while a result is stalled")

endmodule

[tb/sv/click_gesture_classifier_test.sv]
// ----------------------------------------------------------------------------
// click_gesture_classifier_test
// Stream-level check of the click gesture classifier. A mode tracker follows
// every poll transfer, predicts the mode it leads to and compares it with the
// result transfers in order. Directed polls walk the gestures and the limit
// boundaries, then random gesture sequences run under several limit settings
// with random stalls on both stream sides.
// ----------------------------------------------------------------------------

class click_mode_tracker;
    logic [cgc_pkg::LIMIT_W-1:0] double_limit;
    logic [cgc_pkg::LIMIT_W-1:0] long_limit;
    logic [cgc_pkg::MODE_W-1:0]  mode;
    logic [cgc_pkg::NOW_W-1:0]   press_start;
    logic [cgc_pkg::MODE_W-1:0]  expected_modes[$];
    int                          errors;

    function new();
        double_limit = cgc_pkg::DOUBLE_LIMIT_RST;
        long_limit   = cgc_pkg::LONG_LIMIT_RST;
        mode         = cgc_pkg::MODE_IDLE;
        press_start  = '0;
        errors       = 0;
    endfunction

    function void set_register(logic [cgc_pkg::CFG_INDEX_W-1:0] index,
                               logic [cgc_pkg::CFG_DATA_W-1:0] data);
        case (index)
            cgc_pkg::REG_DOUBLE_LIMIT: double_limit = data;
            cgc_pkg::REG_LONG_LIMIT:   long_limit   = data;
            default: ;
        endcase
    endfunction

    function void note_poll(logic [cgc_pkg::NOW_W-1:0] now, bit pressed, bit released);
        logic [cgc_pkg::NOW_W-1:0] elapsed;
        elapsed = now - press_start;
        case (mode)
            cgc_pkg::MODE_IDLE:
            begin
                if (pressed)
                begin
                    press_start = now;
                    mode        = cgc_pkg::MODE_WAIT;
                end
            end
            cgc_pkg::MODE_WAIT:
            begin
                if (released)
                    mode = cgc_pkg::MODE_WAIT_DOUBLE;
                // timeout is tested last, so it wins over the release
                if (elapsed > long_limit)
                    mode = cgc_pkg::MODE_LONG;
            end
            cgc_pkg::MODE_LONG:
            begin
                if (released)
                    mode = cgc_pkg::MODE_IDLE;
            end
            cgc_pkg::MODE_WAIT_DOUBLE:
            begin
                if (pressed)
                    mode = cgc_pkg::MODE_DOUBLE;
                if (elapsed > double_limit)
                    mode = cgc_pkg::MODE_SINGLE;
            end
            cgc_pkg::MODE_SINGLE, cgc_pkg::MODE_DOUBLE:
                mode = cgc_pkg::MODE_IDLE;
            default: ;
        endcase
        expected_modes.push_back(mode);
    endfunction

    function void check_mode(logic [cgc_pkg::MODE_W-1:0] actual);
        logic [cgc_pkg::MODE_W-1:0] wanted;
        if (expected_modes.size() == 0)
        begin
            $error("click_mode: expected none, actual %0d", actual);
            errors++;
        end
        else
        begin
            wanted = expected_modes.pop_front();
            if (actual !== wanted)
            begin
                $error("click_mode: expected %0d, actual %0d", wanted, actual);
                errors++;
            end
        end
    endfunction
endclass

module click_gesture_classifier_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [cgc_pkg::CFG_INDEX_W-1:0] REG_SPARE_A     = 2'd2;
    localparam logic [cgc_pkg::CFG_INDEX_W-1:0] REG_SPARE_B     = 2'd3;
    localparam int                              PHASES          = 9;
    localparam int                              ITEMS_PER_PHASE = 160;

    logic                            clk       = 1'b0;
    logic                            rst_n     = 1'b0;
    logic                            s_tvalid  = 1'b0;
    logic                            s_tready;
    logic [cgc_pkg::S_DATA_W-1:0]    s_tdata   = '0;
    logic                            m_tvalid;
    logic                            m_tready  = 1'b0;
    logic [cgc_pkg::M_DATA_W-1:0]    m_tdata;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [cgc_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [cgc_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;

    click_mode_tracker         tracker;
    bit                        steady = 1'b0;
    logic [cgc_pkg::NOW_W-1:0] cur_time = '0;

    click_gesture_classifier DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #5ms;
        $display("Verification failed");
        $finish;
    end

    function automatic int draw_gap();
        return steady ? 0 : $urandom_range(0, 19);
    endfunction

    // Valid stays high into the next poll when no gap is drawn.
    task automatic send_poll(logic [cgc_pkg::NOW_W-1:0] now, bit pressed, bit released);
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, released, pressed, now};
        do @(posedge clk); while (!s_tready);
        tracker.note_poll(now, pressed, released);
        cur_time = now;
    endtask

    task automatic cfg_write(logic [cgc_pkg::CFG_INDEX_W-1:0] index,
                             logic [cgc_pkg::CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        tracker.set_register(index, data);
    endtask

    // Hold off polls until every result has been taken.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (tracker.expected_modes.size() != 0) @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic run_directed();
        logic [cgc_pkg::NOW_W-1:0] t;
        send_poll(32'h0000_0000, 1'b0, 1'b0);
        send_poll(32'h0000_0001, 1'b0, 1'b1);   // release in idle: drop
        // long press across the time wrap, tie at the limit, then one past it
        t = 32'hFFFF_FF0A;
        send_poll(t, 1'b1, 1'b0);
        send_poll(t + 32'd10, 1'b1, 1'b0);      // press while waiting: drop
        send_poll(t + 32'd700, 1'b0, 1'b0);
        send_poll(t + 32'd701, 1'b0, 1'b0);
        send_poll(t + 32'd800, 1'b1, 1'b0);
        send_poll(t + 32'd900, 1'b0, 1'b1);
        // single click with the double-click window boundary
        t = 32'h0000_1000;
        send_poll(t, 1'b1, 1'b0);
        send_poll(t + 32'd100, 1'b0, 1'b1);
        send_poll(t + 32'd300, 1'b0, 1'b0);
        send_poll(t + 32'd301, 1'b0, 1'b0);
        send_poll(t + 32'd302, 1'b1, 1'b1);     // events in the single poll drop
        // double click
        t = 32'h0000_2000;
        send_poll(t, 1'b1, 1'b0);
        send_poll(t + 32'd50, 1'b0, 1'b1);
        send_poll(t + 32'd120, 1'b1, 1'b0);
        send_poll(t + 32'd121, 1'b1, 1'b1);
        // release past the long limit: timeout wins
        t = 32'h0000_3000;
        send_poll(t, 1'b1, 1'b0);
        send_poll(t + 32'd701, 1'b0, 1'b1);
        send_poll(t + 32'd702, 1'b0, 1'b1);
        // second press past the double-click window: timeout wins
        t = 32'h0000_4000;
        send_poll(t, 1'b1, 1'b0);
        send_poll(t + 32'd10, 1'b0, 1'b1);
        send_poll(t + 32'd301, 1'b1, 1'b0);
        send_poll(t + 32'd302, 1'b0, 1'b0);
        send_poll(32'hFFFF_FFFF, 1'b1, 1'b1);
    endtask

    // Mostly well-formed gestures with random timing; some pure noise.
    task automatic random_poll();
        logic [cgc_pkg::NOW_W-1:0] now;
        logic [cgc_pkg::NOW_W-1:0] elapsed;
        logic [cgc_pkg::NOW_W-1:0] target;
        bit                        pressed;
        bit                        released;
        int                        lim;
        if ($urandom_range(0, 19) == 0)
        begin
            now      = $urandom;
            pressed  = 1'($urandom_range(0, 1));
            released = 1'($urandom_range(0, 1));
        end
        else
        begin
            elapsed = cur_time - tracker.press_start;
            case (tracker.mode)
                cgc_pkg::MODE_WAIT:        lim = tracker.long_limit;
                cgc_pkg::MODE_WAIT_DOUBLE: lim = tracker.double_limit;
                default:                   lim = (tracker.long_limit > tracker.double_limit)
                                                 ? tracker.long_limit : tracker.double_limit;
            endcase
            now = cur_time + $urandom_range(0, lim / 3 + 1);
            // aim at the limit boundary, one below, equal or one above
            if ((tracker.mode == cgc_pkg::MODE_WAIT || tracker.mode == cgc_pkg::MODE_WAIT_DOUBLE)
                && $urandom_range(0, 2) == 0)
            begin
                target = lim - 1 + $urandom_range(0, 2);
                if (target >= elapsed)
                    now = tracker.press_start + target;
            end
            case (tracker.mode)
                cgc_pkg::MODE_IDLE:
                begin
                    pressed  = 1'($urandom_range(0, 1));
                    released = ($urandom_range(0, 3) == 0);
                end
                cgc_pkg::MODE_WAIT, cgc_pkg::MODE_LONG:
                begin
                    pressed  = ($urandom_range(0, 3) == 0);
                    released = ($urandom_range(0, 2) == 0);
                end
                cgc_pkg::MODE_WAIT_DOUBLE:
                begin
                    pressed  = ($urandom_range(0, 2) == 0);
                    released = ($urandom_range(0, 3) == 0);
                end
                default:
                begin
                    pressed  = 1'($urandom_range(0, 1));
                    released = 1'($urandom_range(0, 1));
                end
            endcase
        end
        send_poll(now, pressed, released);
    endtask

    initial
    begin
        int gap;
        wait (rst_n === 1'b1);
        forever
        begin
            gap = draw_gap();
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            tracker.check_mode(m_tdata[cgc_pkg::MODE_W-1:0]);
        end
    end

    initial
    begin
        int dbl_set[PHASES];
        int lng_set[PHASES];
        int wait_cycles;
        dbl_set = '{0, 65535, 15, 40, 65535, 0, 300, 0, 0};
        lng_set = '{0, 65535, 40, 15, 0, 65535, 700, 0, 0};
        dbl_set[7] = $urandom_range(0, 65535);
        lng_set[7] = $urandom_range(0, 65535);
        dbl_set[8] = $urandom_range(1, 200);
        lng_set[8] = $urandom_range(1, 200);
        tracker = new();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();

        for (int ph = 0; ph < PHASES; ph++)
        begin
            drain_results();
            cfg_write(cgc_pkg::REG_DOUBLE_LIMIT, cgc_pkg::CFG_DATA_W'(dbl_set[ph]));
            cfg_write(cgc_pkg::REG_LONG_LIMIT, cgc_pkg::CFG_DATA_W'(lng_set[ph]));
            if (ph % 3 == 2)
            begin
                cfg_write(REG_SPARE_A, cgc_pkg::CFG_DATA_W'($urandom));
                cfg_write(REG_SPARE_B, cgc_pkg::CFG_DATA_W'($urandom));
            end
            cfg_valid <= 1'b0;
            cur_time = $urandom;
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                if (i % 50 == 0)
                    steady = ($urandom_range(0, 3) == 0);
                if (i == ITEMS_PER_PHASE / 2)
                    drain_results();
                random_poll();
            end
        end

        s_tvalid <= 1'b0;
        steady = 1'b0;
        while (tracker.expected_modes.size() != 0) @(posedge clk);
        wait_cycles = 10;
        repeat (wait_cycles) @(posedge clk);
        if (tracker.expected_modes.size() != 0)
        begin
            $error("click_mode: %0d expected results never arrived",
                   tracker.expected_modes.size());
            tracker.errors++;
        end
        if (tracker.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
